### hdl/pwmda_pkg.sv
// ----------------------------------------------------------------------------
// pwmda_pkg
// Types and constants shared by the PWM duty demodulator and averager.
// ----------------------------------------------------------------------------
package pwmda_pkg;

	localparam int TIME_W     = 32;
	localparam int PCT_W      = 7;
	localparam int CODE_W     = 10;

	localparam logic [PCT_W-1:0]  PERCENT_FULL     = 7'd100;
	localparam logic [CODE_W-1:0] FULL_SCALE_RESET = 10'd620;

	// op field codes
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// shared divider: 10 quotient bits, dividend below 1024 times divisor
	localparam int QUO_W      = 10;
	localparam int DIVIDEND_W = 39;
	localparam int DIVISOR_W  = TIME_W;
	localparam int DVS_W      = DIVISOR_W + QUO_W - 1;
	localparam int STEP_W     = $clog2(QUO_W);

	// job queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	typedef struct packed {
		logic              op;
		logic [TIME_W-1:0] capture_time;
	} item_t;

	typedef struct packed {
		logic [CODE_W-1:0] dac_code;
		logic [PCT_W-1:0]  average_percent;
	} result_t;

	typedef enum logic {
		JOB_DUTY,
		JOB_AVG
	} job_kind_t;

	typedef struct packed {
		job_kind_t         kind;
		logic [TIME_W-1:0] high;
		logic [TIME_W-1:0] period;
	} job_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

### hdl/pwmda_if.sv
// ----------------------------------------------------------------------------
// pwmda_if
// Valid/ready channels for input items and for results.
// ----------------------------------------------------------------------------
interface pwmda_item_if;
	logic             valid;
	logic             ready;
	pwmda_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface pwmda_result_if;
	logic               valid;
	logic               ready;
	pwmda_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hdl/pwm_duty_demodulator_averager.sv
// ----------------------------------------------------------------------------
// pwm_duty_demodulator_averager
// PWM duty capture with a moving average scaled to a DAC code.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: op = edge capture (timestamp, alternating rise then fall)
//   or update tick. A rising edge sets the period; a falling edge stores
//   the duty percent into a ring of WINDOW entries; a tick yields one beat
//   on the result channel with the ring average and its DAC code.
//   cfg_we / cfg_wdata write the full scale code; write it only while idle.
// Flow:
//   the front takes an item whenever the queue has room and hands jobs to
//   a two-entry queue. A falling edge job runs the ten-step shared divider
//   in the back, or skips it at full duty or zero period.
//   A tick makes one ring read per entry, then a divide for the mean and
//   a multiply and divide for the DAC code. Sustained rate is set by the
//   back, which runs one job at a time while the front keeps taking items.
// Reset: timing state, ring pointer and ring valid bits clear at once;
//   the ring reads as all zero until written; no clearing pass.
// Stall: a finished result waits in the output register while the front
//   keeps taking items until the queue fills.
// ----------------------------------------------------------------------------
module pwm_duty_demodulator_averager #(
	parameter int WINDOW = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pwmda_pkg::CODE_W-1:0]  cfg_wdata,
	pwmda_item_if.sink                    item,
	pwmda_result_if.source                result
);

	logic [pwmda_pkg::CODE_W-1:0] full_scale_q;
	logic                         push;
	logic                         pop;
	logic                         q_full;
	logic                         q_empty;
	pwmda_pkg::job_t              push_job;
	pwmda_pkg::job_t              head_job;

	// full scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= pwmda_pkg::FULL_SCALE_RESET;
		end else if (cfg_we) begin
			full_scale_q <= cfg_wdata;
		end
	end

	pwmda_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	pwmda_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head     (head_job),
		.empty    (q_empty)
	);

	pwmda_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.full_scale (full_scale_q),
		.job        (head_job),
		.job_valid  (!q_empty),
		.job_pop    (pop),
		.result     (result)
	);

endmodule

### hdl/pwmda_ram.sv
// ----------------------------------------------------------------------------
// pwmda_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pwmda_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/pwmda_div.sv
// ----------------------------------------------------------------------------
// pwmda_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module pwmda_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pwmda_pkg::div_req_t req,
	output pwmda_pkg::div_rsp_t rsp
);

	logic [pwmda_pkg::DIVIDEND_W-1:0] rem_q;
	logic [pwmda_pkg::DVS_W-1:0]      dvs_q;
	logic [pwmda_pkg::QUO_W-1:0]      quo_q;
	logic [pwmda_pkg::STEP_W-1:0]     step_q;
	logic                             busy_q;
	logic                             done_q;
	logic [pwmda_pkg::DVS_W:0]        diff;

	// trial subtraction, borrow in the top bit
	assign diff = (pwmda_pkg::DVS_W + 1)'(rem_q) - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == pwmda_pkg::STEP_W'(pwmda_pkg::QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= req.dividend;
			dvs_q <= {req.divisor, (pwmda_pkg::QUO_W - 1)'(0)};
			quo_q <= '0;
		end else if (busy_q) begin
			if (!diff[pwmda_pkg::DVS_W]) begin
				rem_q <= diff[pwmda_pkg::DIVIDEND_W-1:0];
				quo_q <= {quo_q[pwmda_pkg::QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[pwmda_pkg::QUO_W-2:0], 1'b0};
			end
			dvs_q <= dvs_q >> 1;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### hdl/pwmda_front.sv
// ----------------------------------------------------------------------------
// pwmda_front
// Accepts items, tracks edge timing and turns falling edges and ticks into jobs.
// ----------------------------------------------------------------------------
module pwmda_front (
	input  logic                clk,
	input  logic                arst_n,
	pwmda_item_if.sink          item,
	input  logic                q_full,
	output logic                push,
	output pwmda_pkg::job_t     push_job
);

	logic [pwmda_pkg::TIME_W-1:0] last_edge_q;
	logic [pwmda_pkg::TIME_W-1:0] last_rise_q;
	logic [pwmda_pkg::TIME_W-1:0] period_q;
	logic                         expect_rising_q;
	logic                         accept;
	logic                         is_edge;

	assign item.ready = !q_full;
	assign accept     = item.valid && item.ready;
	assign is_edge    = (item.data.op == pwmda_pkg::OP_EDGE);

	// falling edges and ticks become jobs, rising edges stay here
	assign push = accept && (!is_edge || !expect_rising_q);
	assign push_job = '{
		kind:   is_edge ? pwmda_pkg::JOB_DUTY : pwmda_pkg::JOB_AVG,
		high:   item.data.capture_time - last_edge_q,
		period: period_q
	};

	// edge timing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q     <= '0;
			last_rise_q     <= '0;
			period_q        <= '0;
			expect_rising_q <= 1'b1;
		end else if (accept && is_edge) begin
			if (expect_rising_q) begin
				period_q    <= item.data.capture_time - last_rise_q;
				last_rise_q <= item.data.capture_time;
			end
			expect_rising_q <= !expect_rising_q;
			last_edge_q     <= item.data.capture_time;
		end
	end

endmodule

### hdl/pwmda_queue.sv
// ----------------------------------------------------------------------------
// pwmda_queue
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module pwmda_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pwmda_pkg::job_t push_job,
	output logic            full,
	input  logic            pop,
	output pwmda_pkg::job_t head,
	output logic            empty
);

	pwmda_pkg::job_t               entry_q [pwmda_pkg::QUEUE_DEPTH];
	logic [pwmda_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [pwmda_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [pwmda_pkg::QPTR_W:0]    count_q;

	assign full  = (count_q == (pwmda_pkg::QPTR_W + 1)'(pwmda_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### hdl/pwmda_back.sv
// ----------------------------------------------------------------------------
// pwmda_back
// Runs jobs: duty computation into the ring, and averaging into a result beat.
// ----------------------------------------------------------------------------
module pwmda_back #(
	parameter int WINDOW = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [pwmda_pkg::CODE_W-1:0]  full_scale,
	input  pwmda_pkg::job_t               job,
	input  logic                          job_valid,
	output logic                          job_pop,
	pwmda_result_if.source                result
);

	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = $clog2(WINDOW * 100 + 1);
	localparam int MUL_W = pwmda_pkg::TIME_W + pwmda_pkg::CODE_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_DUTY_DIV,
		S_DUTY_WAIT,
		S_WRITE,
		S_SUM,
		S_AVG_DIV,
		S_AVG_WAIT,
		S_DAC_MUL,
		S_DAC_DIV,
		S_DAC_WAIT,
		S_EMIT
	} state_t;

	state_t                          state_q;
	pwmda_pkg::job_t                 job_q;
	logic [pwmda_pkg::PCT_W-1:0]     duty_q;
	logic [pwmda_pkg::PCT_W-1:0]     avg_q;
	logic [IDX_W-1:0]                ring_idx_q;
	logic [WINDOW-1:0]               valid_q;
	logic [CNT_W-1:0]                rd_cnt_q;
	logic                            rd_pend_s1;
	logic                            vbit_s1;
	logic [SUM_W-1:0]                sum_q;
	logic [pwmda_pkg::DIVIDEND_W-1:0] prod_q;
	logic                            res_valid_q;
	pwmda_pkg::result_t              res_data_q;

	logic [pwmda_pkg::TIME_W-1:0]    mul_a;
	logic [pwmda_pkg::CODE_W-1:0]    mul_b;
	logic [MUL_W-1:0]                prod_full;
	logic                            rd_issue;
	logic [IDX_W-1:0]                raddr;
	logic [pwmda_pkg::PCT_W-1:0]     rdata;
	logic                            emit_ok;
	pwmda_pkg::div_req_t             div_req;
	pwmda_pkg::div_rsp_t             div_rsp;

	assign job_pop = (state_q == S_IDLE) && job_valid;

	// shared multiplier: high time by 100, or average by full scale
	assign mul_a = (state_q == S_DAC_MUL) ? pwmda_pkg::TIME_W'(avg_q) : job_q.high;
	assign mul_b = (state_q == S_DAC_MUL) ? full_scale
	                                      : pwmda_pkg::CODE_W'(pwmda_pkg::PERCENT_FULL);
	assign prod_full = MUL_W'(mul_a) * MUL_W'(mul_b);

	// ring sweep read address
	assign rd_issue = (state_q == S_SUM) && (rd_cnt_q < CNT_W'(WINDOW));
	assign raddr    = rd_issue ? rd_cnt_q[IDX_W-1:0] : '0;

	// divider requests
	always_comb begin
		div_req.start    = (state_q == S_DUTY_DIV) || (state_q == S_AVG_DIV) ||
		                   (state_q == S_DAC_DIV);
		div_req.dividend = (state_q == S_AVG_DIV) ? pwmda_pkg::DIVIDEND_W'(sum_q) : prod_q;
		case (state_q)
			S_DUTY_DIV: div_req.divisor = job_q.period;
			S_AVG_DIV:  div_req.divisor = pwmda_pkg::DIVISOR_W'(WINDOW);
			default:    div_req.divisor = pwmda_pkg::DIVISOR_W'(pwmda_pkg::PERCENT_FULL);
		endcase
	end

	assign emit_ok = !res_valid_q || result.ready;

	pwmda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	pwmda_ram #(
		.WIDTH (pwmda_pkg::PCT_W),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (state_q == S_WRITE),
		.waddr (ring_idx_q),
		.wdata (duty_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// sequencer state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ring_idx_q  <= '0;
			valid_q     <= '0;
			rd_pend_s1  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_issue;
			// result register: load on emit, clear once the beat is taken
			if (state_q == S_EMIT && emit_ok) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (job_q.kind == pwmda_pkg::JOB_AVG) begin
						state_q <= S_SUM;
					end else if (job_q.period == '0 || job_q.high >= job_q.period) begin
						state_q <= S_WRITE;
					end else begin
						state_q <= S_DUTY_DIV;
					end
				end
				S_DUTY_DIV:  state_q <= S_DUTY_WAIT;
				S_DUTY_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					valid_q[ring_idx_q] <= 1'b1;
					ring_idx_q <= (ring_idx_q == IDX_W'(WINDOW - 1)) ? '0 : ring_idx_q + 1'b1;
					state_q    <= S_IDLE;
				end
				S_SUM: begin
					if (!rd_issue && !rd_pend_s1) begin
						state_q <= S_AVG_DIV;
					end
				end
				S_AVG_DIV:  state_q <= S_AVG_WAIT;
				S_AVG_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_DAC_MUL;
					end
				end
				S_DAC_MUL:  state_q <= S_DAC_DIV;
				S_DAC_DIV:  state_q <= S_DAC_WAIT;
				S_DAC_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		vbit_s1 <= valid_q[raddr];
		if (job_pop) begin
			job_q <= job;
		end
		if (state_q == S_LOAD) begin
			prod_q   <= prod_full[pwmda_pkg::DIVIDEND_W-1:0];
			sum_q    <= '0;
			rd_cnt_q <= '0;
			if (job_q.period == '0) begin
				duty_q <= '0;
			end else begin
				duty_q <= pwmda_pkg::PERCENT_FULL;
			end
		end
		if (state_q == S_DAC_MUL) begin
			prod_q <= prod_full[pwmda_pkg::DIVIDEND_W-1:0];
		end
		if (state_q == S_DUTY_WAIT && div_rsp.done) begin
			duty_q <= div_rsp.quotient[pwmda_pkg::PCT_W-1:0];
		end
		if (rd_issue) begin
			rd_cnt_q <= rd_cnt_q + 1'b1;
		end
		// unwritten ring entries count as zero
		if (state_q == S_SUM && rd_pend_s1 && vbit_s1) begin
			sum_q <= sum_q + SUM_W'(rdata);
		end
		if (state_q == S_AVG_WAIT && div_rsp.done) begin
			avg_q <= div_rsp.quotient[pwmda_pkg::PCT_W-1:0];
		end
		if (state_q == S_EMIT && emit_ok) begin
			res_data_q.dac_code        <= div_rsp.quotient;
			res_data_q.average_percent <= avg_q;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_data_q;

	// ring pointer never leaves the window
	a_ring_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		ring_idx_q <= IDX_W'(WINDOW - 1))
		else $error("ring index out of window");

	// the shared divider is only started when free
	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// a loaded average never exceeds full duty
	a_avg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && emit_ok) |-> (avg_q <= pwmda_pkg::PERCENT_FULL))
		else $error("average above full duty");

	// a duty job goes through the divider only below full duty
	a_duty_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUTY_DIV) |-> (job_q.high < job_q.period))
		else $error("duty division without fraction");

endmodule

### tb/sv/pwm_duty_demodulator_averager_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwm_duty_demodulator_averager_tb
// Self-checking bench for the PWM duty demodulator and averager. A short
// stimulus table covers reset, zero period, saturation, timer wrap and ring
// wrap; random edge and tick streams follow under several full scale codes.
// Each result beat is checked against a table code or a tracked duty ring.
// ----------------------------------------------------------------------------
module pwm_duty_demodulator_averager_tb;

	localparam int WINDOW        = 10;
	localparam int SEG_ITEMS     = 170;
	localparam int SEGMENTS      = 6;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 400;
	localparam int SCALE_RANDOM  = -1;

	typedef struct packed {
		logic                         op;
		logic [pwmda_pkg::TIME_W-1:0] stamp;
		bit                           fixed;
		logic [pwmda_pkg::CODE_W-1:0] code;
		logic [pwmda_pkg::PCT_W-1:0]  pct;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [pwmda_pkg::CODE_W-1:0] cfg_wdata;

	pwmda_item_if   item_ch ();
	pwmda_result_if result_ch ();

	pwm_duty_demodulator_averager #(
		.WINDOW (WINDOW)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	// duty tracking state, mirrors the block
	logic [pwmda_pkg::TIME_W-1:0] edge_time   = '0;
	logic [pwmda_pkg::TIME_W-1:0] rise_time   = '0;
	logic [pwmda_pkg::TIME_W-1:0] period_len  = '0;
	bit                           want_rise   = 1'b1;
	logic [pwmda_pkg::PCT_W-1:0]  duty_hist [WINDOW];
	int                           hist_pos    = 0;
	logic [pwmda_pkg::CODE_W-1:0] full_scale  = pwmda_pkg::FULL_SCALE_RESET;

	pwmda_pkg::result_t pending_codes [$];
	int                 err_count = 0;
	bit                 hold_req  = 1'b0;
	bit                 calm      = 1'b0;

	// directed beats: reset, zero period, saturation, timer wrap, ring wrap
	script_row_t script [26] = '{
		'{pwmda_pkg::OP_TICK, 32'h0000_0000, 1'b1, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_0000, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_0032, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b1, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_03E8, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_09C4, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_TICK, 32'h0000_0000, 1'b1, 10'd62, 7'd10},
		'{pwmda_pkg::OP_EDGE, 32'h0000_07D0, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_09C4, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_TICK, 32'h5555_AAAA, 1'b1, 10'd93, 7'd15},
		'{pwmda_pkg::OP_EDGE, 32'hFFFF_FF00, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_0010, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_0100, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_0280, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'hFFFF_FFFF, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'hFFFF_FFFF, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_TICK, 32'hAAAA_5555, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_1000, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_1800, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_2000, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_2FFF, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_3000, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_4000, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_4000, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_EDGE, 32'h0000_4001, 1'b0, 10'd0,  7'd0},
		'{pwmda_pkg::OP_TICK, 32'h0000_0000, 1'b0, 10'd0,  7'd0}
	};

	int scale_plan [SEGMENTS] = '{1023, 0, 1, SCALE_RANDOM, SCALE_RANDOM, 620};

	// duty percent of one high time, zero for no period, capped at full
	function automatic logic [pwmda_pkg::PCT_W-1:0] duty_of(
			logic [pwmda_pkg::TIME_W-1:0] high, logic [pwmda_pkg::TIME_W-1:0] per);
		longint unsigned wide_high;
		longint unsigned q;
		if (per == '0)
			return '0;
		wide_high = high;
		q = (wide_high * 100) / per;
		if (q > 100)
			return pwmda_pkg::PERCENT_FULL;
		return q[pwmda_pkg::PCT_W-1:0];
	endfunction

	// apply one accepted beat to the duty ring, return 1 with the tick result
	function automatic bit absorb_item(input pwmda_pkg::item_t it,
			output pwmda_pkg::result_t res);
		int unsigned sum;
		int unsigned avg;
		int unsigned code;
		res = '0;
		if (it.op == pwmda_pkg::OP_EDGE) begin
			if (want_rise) begin
				period_len = it.capture_time - rise_time;
				rise_time  = it.capture_time;
				want_rise  = 1'b0;
			end else begin
				duty_hist[hist_pos] = duty_of(it.capture_time - edge_time, period_len);
				hist_pos  = (hist_pos == WINDOW - 1) ? 0 : hist_pos + 1;
				want_rise = 1'b1;
			end
			edge_time = it.capture_time;
			return 1'b0;
		end
		sum = 0;
		for (int i = 0; i < WINDOW; i++)
			sum += duty_hist[i];
		avg  = sum / WINDOW;
		code = (avg * int'(full_scale)) / 100;
		res.dac_code        = code[pwmda_pkg::CODE_W-1:0];
		res.average_percent = avg[pwmda_pkg::PCT_W-1:0];
		return 1'b1;
	endfunction

	// mostly well-formed edges with random period and high time, some noise
	function automatic pwmda_pkg::item_t random_item();
		pwmda_pkg::item_t             it;
		int unsigned                  pick;
		logic [pwmda_pkg::TIME_W-1:0] span;
		it.op = ($urandom_range(0, 3) == 0) ? pwmda_pkg::OP_TICK : pwmda_pkg::OP_EDGE;
		it.capture_time = $urandom;
		if (it.op == pwmda_pkg::OP_EDGE) begin
			pick = $urandom_range(0, 9);
			if (want_rise) begin
				span = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 5000);
				if (pick == 1)
					it.capture_time = rise_time;
				else if (pick > 1)
					it.capture_time = rise_time + span;
			end else begin
				if (pick == 1)
					it.capture_time = edge_time + period_len + $urandom_range(1, 1000);
				else if (pick > 1)
					it.capture_time = edge_time + $urandom_range(period_len, 0);
			end
		end
		return it;
	endfunction

	task automatic note_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		err_count++;
		if (err_count <= 10)
			$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
	endtask

	// offer one beat, record its result on acceptance
	task automatic send_item(input pwmda_pkg::item_t it, input bit fixed,
			input pwmda_pkg::result_t fixed_res);
		pwmda_pkg::result_t res;
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		if (absorb_item(it, res))
			pending_codes.push_back(fixed ? fixed_res : res);
	endtask

	// drain results and let edge jobs finish before touching the register
	task automatic set_full_scale(input logic [pwmda_pkg::CODE_W-1:0] value);
		item_ch.valid <= 1'b0;
		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		full_scale = value;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// result ready with random stalls and one long hold-off
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_ch.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// compare each result beat with the oldest expected code
	always @(posedge clk) begin : watch_results
		pwmda_pkg::result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_codes.size() == 0) begin
				note_mismatch("unexpected beat, dac_code", 0, result_ch.data.dac_code);
			end else begin
				want = pending_codes.pop_front();
				if (result_ch.data.dac_code !== want.dac_code)
					note_mismatch("dac_code", want.dac_code, result_ch.data.dac_code);
				if (result_ch.data.average_percent !== want.average_percent)
					note_mismatch("average_percent", want.average_percent,
						result_ch.data.average_percent);
			end
		end
	end

	// stimulus
	initial begin
		pwmda_pkg::item_t   it;
		pwmda_pkg::result_t typed;
		int                 scale;
		foreach (duty_hist[i])
			duty_hist[i] = '0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		item_ch.valid <= 1'b0;
		item_ch.data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the reset full scale code
		foreach (script[i]) begin
			it.op                 = script[i].op;
			it.capture_time       = script[i].stamp;
			typed.dac_code        = script[i].code;
			typed.average_percent = script[i].pct;
			send_item(it, script[i].fixed, typed);
		end

		// random segments, one full scale code each, last one without idling
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			scale = (scale_plan[seg] == SCALE_RANDOM) ? $urandom_range(0, 1023) : scale_plan[seg];
			set_full_scale(scale[pwmda_pkg::CODE_W-1:0]);
			if (seg == SEGMENTS - 1)
				calm = 1'b1;
			for (int n = 0; n < SEG_ITEMS; n++) begin
				if (seg == 1 && n == 40)
					hold_req = 1'b1;
				send_item(random_item(), 1'b0, '0);
			end
		end

		// drain and let late beats show up
		item_ch.valid <= 1'b0;
		while (pending_codes.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### pwm_duty_demodulator_averager.f
hdl/pwmda_pkg.sv
hdl/pwmda_if.sv
hdl/pwmda_ram.sv
hdl/pwmda_div.sv
hdl/pwmda_front.sv
hdl/pwmda_queue.sv
hdl/pwmda_back.sv
hdl/pwm_duty_demodulator_averager.sv
tb/sv/pwm_duty_demodulator_averager_tb.sv
